/* rtl/psu_pkg.sv */
// package for the particle store update block
// shared types, constants and lane helpers; no dependencies
package psu_pkg;

  localparam int unsigned MAX_PARTICLES = 512;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned CNT_W = 10;
  localparam int unsigned VEC_W = 63;
  localparam int unsigned COL_W = 64;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned T_W = 16;
  localparam int unsigned LANE_W = 21;
  localparam int unsigned CLANE_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } psu_op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NOLIVE = 2'd2
  } psu_stat_e;

  typedef enum logic [2:0] {
    CFG_DT      = 3'd0,
    CFG_FS      = 3'd1,
    CFG_ACC     = 3'd2,
    CFG_ESCALE  = 3'd3,
    CFG_SCOL    = 3'd4,
    CFG_ECOL    = 3'd5,
    CFG_LIFE    = 3'd6,
    CFG_BB      = 3'd7
  } psu_cfg_e;

  typedef enum logic [1:0] {
    WR_SPAWN = 2'd0,
    WR_MOVE  = 2'd1,
    WR_UPD   = 2'd2
  } psu_wsel_e;

  typedef struct packed {
    logic [VEC_W-1:0]  pos;
    logic [VEC_W-1:0]  vel;
    logic [VEC_W-1:0]  acc;
    logic [VEC_W-1:0]  scl_now;
    logic [VEC_W-1:0]  scl_st;
    logic [VEC_W-1:0]  scl_end;
    logic [VEC_W-1:0]  rot;
    logic [COL_W-1:0]  col_now;
    logic [COL_W-1:0]  col_st;
    logic [COL_W-1:0]  col_end;
    logic [TIME_W-1:0] life;
    logic [TIME_W-1:0] age;
    logic              bb;
  } psu_ent_t;

  typedef struct packed {
    logic             in_load;
    logic             mem_we;
    psu_wsel_e        mem_wsel;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             div_start;
    logic             ent_load;
    logic             out_load;
    logic             out_rd;
    psu_stat_e        out_status;
    logic [CNT_W-1:0] out_live;
  } psu_cmd_t;

  typedef struct packed {
    logic dead;
    logic div_done;
  } psu_sts_t;

  function automatic logic [LANE_W-1:0] sat21(input logic signed [39:0] v);
    logic [LANE_W-1:0] r;
    if (v > 40'sd1048575) begin
      r = 21'h0FFFFF;
    end else if (v < -40'sd1048576) begin
      r = 21'h100000;
    end else begin
      r = v[LANE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CLANE_W-1:0] sat16(input logic signed [19:0] v);
    logic [CLANE_W-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[CLANE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/particle_store_update_top.sv */
// top level of the particle store update block
// spawn appends an entry (or reports full), clear empties the store, read returns the entry
// at the index (or reports it not live), tick steps live entries and drops expired ones;
// one item at a time, taken only in idle and once the last result can be handed on
// reset clears control and live count, sets config defaults; the store is never cleared
module particle_store_update_top import psu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index, spawn_position, spawn_scale, spawn_velocity, spawn_rotate, zero pad
  input  logic [263:0]          s_axis_tdata,
  // opcode
  input  logic [1:0]            s_axis_tuser,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // live_total, out_position, out_scale, out_rotate, out_color, out_billboard
  output logic [263:0]          m_axis_tdata,
  // status
  output logic [1:0]            m_axis_tuser
);

  psu_cmd_t cmd;
  psu_sts_t sts;

  logic [CNT_W-1:0] live;
  logic [VEC_W-1:0] opos, oscl, orot;
  logic [COL_W-1:0] ocol;
  logic             obb;

  // controller sequences every opcode and owns the live count
  psu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_idx_i    (s_axis_tdata[8:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath holds the store, the arithmetic and the result register
  psu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_pos_i     (s_axis_tdata[71:9]),
    .in_scl_i     (s_axis_tdata[134:72]),
    .in_vel_i     (s_axis_tdata[197:135]),
    .in_rot_i     (s_axis_tdata[260:198]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_status_o (m_axis_tuser),
    .out_live_o   (live),
    .out_pos_o    (opos),
    .out_scl_o    (oscl),
    .out_rot_o    (orot),
    .out_col_o    (ocol),
    .out_bb_o     (obb)
  );

  assign m_axis_tdata = {obb, ocol, orot, oscl, opos, live};

endmodule

/* rtl/psu_div.sv */
// restoring divider giving t = age * 2^16 / life, one quotient bit a cycle
// needs age < life; depends on psu_pkg
module psu_div import psu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [T_W-1:0]    quot_o
);

  logic              busy_q, busy_d;
  logic [4:0]        n_q, n_d;
  logic [TIME_W:0]   rem_q, rem_d;
  logic [T_W-1:0]    q_q, q_d;
  logic [TIME_W-1:0] den_q, den_d;
  logic [TIME_W:0]   r2;

  always_comb begin
    busy_d = busy_q;
    n_d    = n_q;
    rem_d  = rem_q;
    q_d    = q_q;
    den_d  = den_q;
    r2     = {rem_q[TIME_W-1:0], 1'b0};
    if (start_i) begin
      busy_d = 1'b1;
      n_d    = 5'(T_W);
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      q_d    = '0;
    end else if (busy_q) begin
      if (r2 >= {1'b0, den_q}) begin
        rem_d = r2 - {1'b0, den_q};
        q_d   = {q_q[T_W-2:0], 1'b1};
      end else begin
        rem_d = r2;
        q_d   = {q_q[T_W-2:0], 1'b0};
      end
      n_d    = n_q - 5'd1;
      busy_d = (n_q != 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
    end else begin
      busy_q <= busy_d;
      n_q    <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_d;
  end

  assign done_o = !busy_q;
  assign quot_o = q_q;

endmodule

/* rtl/psu_dp.sv */
// datapath: config registers, particle store memory, tick arithmetic, result register
// depends on psu_pkg and psu_div
module psu_dp import psu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [VEC_W-1:0]      in_pos_i,
  input  logic [VEC_W-1:0]      in_scl_i,
  input  logic [VEC_W-1:0]      in_vel_i,
  input  logic [VEC_W-1:0]      in_rot_i,
  input  psu_cmd_t              cmd_i,
  output psu_sts_t              sts_o,
  output logic [1:0]            out_status_o,
  output logic [CNT_W-1:0]      out_live_o,
  output logic [VEC_W-1:0]      out_pos_o,
  output logic [VEC_W-1:0]      out_scl_o,
  output logic [VEC_W-1:0]      out_rot_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic                  out_bb_o
);

  logic [TIME_W-1:0] dt_q, fs_q, life_q;
  logic [VEC_W-1:0]  acc_q, escl_q;
  logic [COL_W-1:0]  scol_q, ecol_q;
  logic              bb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= 32'd1092;
      fs_q   <= 32'd65536;
      acc_q  <= '0;
      escl_q <= '0;
      scol_q <= '0;
      ecol_q <= '0;
      life_q <= 32'd65536;
      bb_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (psu_cfg_e'(cfg_idx_i))
        CFG_DT:     dt_q   <= cfg_data_i[TIME_W-1:0];
        CFG_FS:     fs_q   <= cfg_data_i[TIME_W-1:0];
        CFG_ACC:    acc_q  <= cfg_data_i[VEC_W-1:0];
        CFG_ESCALE: escl_q <= cfg_data_i[VEC_W-1:0];
        CFG_SCOL:   scol_q <= cfg_data_i;
        CFG_ECOL:   ecol_q <= cfg_data_i;
        CFG_LIFE:   life_q <= cfg_data_i[TIME_W-1:0];
        CFG_BB:     bb_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // latched spawn payload
  logic [VEC_W-1:0] pos_q, scl_q, vel_q, rot_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      pos_q <= in_pos_i;
      scl_q <= in_scl_i;
      vel_q <= in_vel_i;
      rot_q <= in_rot_i;
    end
  end

  // particle store
  psu_ent_t mem [MAX_PARTICLES];
  psu_ent_t rd_q, ent_q, wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[cmd_i.mem_waddr] <= wd;
    end
    if (cmd_i.mem_re) begin
      rd_q <= mem[cmd_i.mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_load) begin
      ent_q <= rd_q;
    end
  end

  // t from the shared divider, started from the entry as it comes out of the store
  logic [T_W-1:0] t;
  logic           div_done;
  psu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (rd_q.age),
    .den_i   (rd_q.life),
    .done_o  (div_done),
    .quot_o  (t)
  );

  // products, registered
  logic signed [53:0] pp_q [3];
  logic signed [53:0] vp_q [3];
  logic signed [38:0] sp_q [3];
  logic signed [33:0] cp_q [4];
  logic signed [21:0] sdiff [3];
  logic signed [16:0] cdiff [4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sdiff[k] = $signed(ent_q.scl_end[LANE_W*k +: LANE_W])
               - $signed(ent_q.scl_st[LANE_W*k +: LANE_W]);
    end
    for (int k = 0; k < 4; k++) begin
      cdiff[k] = $signed(ent_q.col_end[CLANE_W*k +: CLANE_W])
               - $signed(ent_q.col_st[CLANE_W*k +: CLANE_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pp_q[k] <= $signed(ent_q.vel[LANE_W*k +: LANE_W]) * $signed({1'b0, fs_q});
      vp_q[k] <= $signed(ent_q.acc[LANE_W*k +: LANE_W]) * $signed({1'b0, fs_q});
      sp_q[k] <= sdiff[k] * $signed({1'b0, t});
    end
    for (int k = 0; k < 4; k++) begin
      cp_q[k] <= cdiff[k] * $signed({1'b0, t});
    end
  end

  // write-back entry
  psu_ent_t           upd;
  logic signed [39:0] s40;
  logic signed [19:0] s20;
  logic [TIME_W:0]    age_sum;

  always_comb begin
    upd = ent_q;
    for (int k = 0; k < 3; k++) begin
      s40 = $signed(ent_q.pos[LANE_W*k +: LANE_W]) + $signed(pp_q[k][53:16]);
      upd.pos[LANE_W*k +: LANE_W] = sat21(s40);
      s40 = $signed(ent_q.vel[LANE_W*k +: LANE_W]) + $signed(vp_q[k][53:16]);
      upd.vel[LANE_W*k +: LANE_W] = sat21(s40);
      s40 = $signed(ent_q.scl_st[LANE_W*k +: LANE_W]) + $signed(sp_q[k][38:16]);
      upd.scl_now[LANE_W*k +: LANE_W] = sat21(s40);
    end
    for (int k = 0; k < 4; k++) begin
      s20 = $signed(ent_q.col_st[CLANE_W*k +: CLANE_W]) + $signed(cp_q[k][33:16]);
      upd.col_now[CLANE_W*k +: CLANE_W] = sat16(s20);
    end
    age_sum = {1'b0, ent_q.age} + {1'b0, dt_q};
    upd.age = age_sum[TIME_W] ? '1 : age_sum[TIME_W-1:0];
  end

  always_comb begin
    case (cmd_i.mem_wsel)
      WR_SPAWN: begin
        wd.pos     = pos_q;
        wd.vel     = vel_q;
        wd.acc     = acc_q;
        wd.scl_now = scl_q;
        wd.scl_st  = scl_q;
        wd.scl_end = escl_q;
        wd.rot     = rot_q;
        wd.col_now = scol_q;
        wd.col_st  = scol_q;
        wd.col_end = ecol_q;
        wd.life    = life_q;
        wd.age     = '0;
        wd.bb      = bb_q;
      end
      WR_MOVE: wd = rd_q;
      default: wd = upd;
    endcase
  end

  assign sts_o.dead     = (rd_q.age >= rd_q.life);
  assign sts_o.div_done = div_done;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o <= cmd_i.out_status;
      out_live_o   <= cmd_i.out_live;
      if (cmd_i.out_rd) begin
        out_pos_o <= rd_q.pos;
        out_scl_o <= rd_q.scl_now;
        out_rot_o <= rd_q.rot;
        out_col_o <= rd_q.col_now;
        out_bb_o  <= rd_q.bb;
      end else begin
        out_pos_o <= '0;
        out_scl_o <= '0;
        out_rot_o <= '0;
        out_col_o <= '0;
        out_bb_o  <= 1'b0;
      end
    end
  end

endmodule

/* rtl/psu_ctrl.sv */
// controller: opcode sequencing, live count, tick walk and handshakes
// depends on psu_pkg
module psu_ctrl import psu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_op_i,
  input  logic [IDX_W-1:0] in_idx_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  psu_sts_t         sts_i,
  output psu_cmd_t         cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_SPAWN   = 10'b0000000010,
    ST_RD      = 10'b0000000100,
    ST_RD_WAIT = 10'b0000001000,
    ST_TK_RD   = 10'b0000010000,
    ST_TK_CHK  = 10'b0000100000,
    ST_TK_MOV  = 10'b0001000000,
    ST_TK_DIV  = 10'b0010000000,
    ST_TK_LRP  = 10'b0100000000,
    ST_TK_WB   = 10'b1000000000
  } psu_state_e;

  psu_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, cm1;
  logic [IDX_W-1:0] idx_q;
  logic             ov_q, ov_d;
  logic             accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!ov_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign cm1         = cnt_q - CNT_W'(1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    cmd_o   = '0;
    cmd_o.mem_wsel   = WR_SPAWN;
    cmd_o.out_status = STAT_OK;
    cmd_o.out_live   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.in_load = 1'b1;
          case (psu_op_e'(in_op_i))
            OP_SPAWN: state_d = ST_SPAWN;
            OP_TICK: begin
              i_d     = '0;
              state_d = ST_TK_RD;
            end
            OP_READ: state_d = ST_RD;
            default: begin
              cnt_d           = '0;
              cmd_o.out_load  = 1'b1;
              cmd_o.out_live  = '0;
            end
          endcase
        end
      end
      ST_SPAWN: begin
        cmd_o.out_load = 1'b1;
        if (cnt_q == CNT_W'(MAX_PARTICLES)) begin
          cmd_o.out_status = STAT_FULL;
        end else begin
          cmd_o.mem_we    = 1'b1;
          cmd_o.mem_waddr = cnt_q[IDX_W-1:0];
          cnt_d           = cnt_q + CNT_W'(1);
          cmd_o.out_live  = cnt_d;
        end
        state_d = ST_IDLE;
      end
      ST_RD: begin
        if ({1'b0, idx_q} >= cnt_q) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = STAT_NOLIVE;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.mem_re    = 1'b1;
          cmd_o.mem_raddr = idx_q;
          state_d         = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_rd   = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_TK_RD: begin
        if (i_q >= cnt_q) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.mem_re    = 1'b1;
          cmd_o.mem_raddr = i_q[IDX_W-1:0];
          state_d         = ST_TK_CHK;
        end
      end
      ST_TK_CHK: begin
        cmd_o.ent_load = 1'b1;
        if (sts_i.dead) begin
          cnt_d = cm1;
          if (cm1 != i_q) begin
            cmd_o.mem_re    = 1'b1;
            cmd_o.mem_raddr = cm1[IDX_W-1:0];
            state_d         = ST_TK_MOV;
          end else begin
            state_d = ST_TK_RD;
          end
        end else begin
          state_d = ST_TK_DIV;
        end
      end
      ST_TK_MOV: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_wsel  = WR_MOVE;
        cmd_o.mem_waddr = i_q[IDX_W-1:0];
        state_d         = ST_TK_RD;
      end
      ST_TK_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_TK_LRP;
        end
      end
      ST_TK_LRP: state_d = ST_TK_WB;
      ST_TK_WB: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_wsel  = WR_UPD;
        cmd_o.mem_waddr = i_q[IDX_W-1:0];
        i_d             = i_q + CNT_W'(1);
        state_d         = ST_TK_RD;
      end
      default: state_d = ST_IDLE;
    endcase
    // divider starts as the entry is captured
    cmd_o.div_start = (state_q == ST_TK_CHK) && !sts_i.dead;
  end

  always_comb begin
    if (cmd_o.out_load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= in_idx_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PARTICLES)) else $error("live count above capacity");
  a_mov_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TK_MOV) |-> (i_q < cnt_q)) else $error("move from a dead slot");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op_i == OP_CLEAR) |=> (cnt_q == '0)) else $error("clear left entries");
  a_spawn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPAWN && cnt_q != CNT_W'(MAX_PARTICLES)) |=>
    (cnt_q == $past(cnt_q) + CNT_W'(1))) else $error("spawn did not grow store");
`endif

endmodule
